@@ design/joint_ramp_then_sine_trajectory_macros.svh @@
// Assertion macros shared by the trajectory generator modules.
`ifndef JOINT_RAMP_THEN_SINE_TRAJECTORY_MACROS_SVH
`define JOINT_RAMP_THEN_SINE_TRAJECTORY_MACROS_SVH

// same-cycle implication
`define JRST_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("jrst assertion failed");

// next-cycle implication
`define JRST_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("jrst assertion failed");

`endif

@@ design/jrst_pkg.sv @@
// Shared types, constants and helper functions of the trajectory generator.
package jrst_pkg;

	localparam int SINE_TABLE_BITS = 10;
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_POS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SWING_AMP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_VEL_SCALE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_P      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_D      = 3'd6;

	localparam logic [16:0] WEIGHT_ONE    = 17'd65536;
	localparam logic [15:0] RAMP_STEP_RST = 16'd22;
	localparam logic [30:0] Q30_ONE       = 31'h4000_0000;

	localparam logic [31:0] SIN_C1 = 32'd1686629713;
	localparam logic [31:0] SIN_C3 = 32'd693598668;
	localparam logic [31:0] SIN_C5 = 32'd85569306;
	localparam logic [31:0] SIN_C7 = 32'd5026993;
	localparam logic [31:0] SIN_C9 = 32'd172273;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_ENTER,
		OP_RAMP_MUL,
		OP_RAMP_FIN,
		OP_SIN_SETUP,
		OP_X2_MUL,
		OP_X2_FIN,
		OP_T_MUL,
		OP_T_FIN,
		OP_R_MUL,
		OP_R_FIN,
		OP_AV_MUL,
		OP_AV_FIN,
		OP_POS_MUL,
		OP_POS_FIN,
		OP_VEL_MUL,
		OP_SWING_FIN
	} dp_op_t;

	typedef struct packed {
		dp_op_t     op;
		logic       cos_sel;
		logic [1:0] coef;
	} dp_cmd_t;

	typedef struct packed {
		logic swinging;
	} dp_stat_t;

	// Horner coefficients after C9, in order of use
	function automatic logic [31:0] sin_coef(input logic [1:0] k);
		unique case (k)
			2'd0: return SIN_C7;
			2'd1: return SIN_C5;
			2'd2: return SIN_C3;
			2'd3: return SIN_C1;
		endcase
	endfunction

	function automatic logic signed [15:0] sat16(input logic signed [23:0] v);
		if (v > 24'sd32767)
			return 16'sh7fff;
		else if (v < -24'sd32768)
			return 16'sh8000;
		else
			return v[15:0];
	endfunction

endpackage

@@ design/jrst_dp.sv @@
// Datapath: configuration, joint state, shared multiplier and sine evaluation.
`include "joint_ramp_then_sine_trajectory_macros.svh"

module jrst_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  jrst_pkg::dp_cmd_t              cmd,
	output jrst_pkg::dp_stat_t             stat,
	input  logic signed [15:0]             measured_pos,
	input  logic                           cfg_valid,
	input  logic [jrst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data,
	output logic signed [15:0]             target_pos,
	output logic signed [15:0]             ref_vel,
	output logic [15:0]                    gain_p,
	output logic [15:0]                    gain_d,
	output logic                           in_swing
);

	localparam int TB = jrst_pkg::SINE_TABLE_BITS;
	localparam logic [TB-1:0] QUARTER = TB'(1) << (TB - 2);

	// configuration
	logic signed [15:0] default_pos_q;
	logic [14:0]        swing_amp_q;
	logic [31:0]        phase_step_q;
	logic [15:0]        vel_scale_q;
	logic [15:0]        ramp_step_q;
	logic [15:0]        gain_p_q;
	logic [15:0]        gain_d_q;

	// joint state
	logic signed [15:0] start_q;
	logic [16:0]        weight_q;
	logic [31:0]        phase_q;
	logic               swinging_q;

	// working registers
	logic [63:0]        prod_q;
	logic               neg_q;
	logic [30:0]        x_q;
	logic [30:0]        x2_q;
	logic [31:0]        t_q;
	logic [1:0]         quad_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;
	logic [30:0]        av_q;
	logic signed [15:0] pos_q;

	logic signed [16:0] diff;
	logic               diff_neg;
	logic [16:0]        diff_mag;
	logic [14:0]        sin_mag;
	logic [14:0]        cos_mag;
	logic [31:0]        mul_a;
	logic [31:0]        mul_b;
	logic               mul_neg;
	logic [TB-1:0]      idx;
	logic [31:0]        q;
	logic [30:0]        x_raw;
	logic [32:0]        r_full;
	logic [33:0]        r_sum;
	logic [18:0]        r_q15;
	logic [14:0]        r_mag;
	logic signed [15:0] r_signed;
	logic signed [63:0] sprod;
	logic signed [63:0] sh15;
	logic signed [63:0] sh16;
	logic signed [63:0] sh27;
	logic [15:0]        step_eff;
	logic [17:0]        weight_nx;

	assign stat.swinging = swinging_q;

	assign diff     = {default_pos_q[15], default_pos_q} - {start_q[15], start_q};
	assign diff_neg = diff[16];
	assign diff_mag = diff_neg ? 17'(-diff) : 17'(diff);
	assign sin_mag  = sin_q[15] ? 15'(-sin_q) : sin_q[14:0];
	assign cos_mag  = cos_q[15] ? 15'(-cos_q) : cos_q[14:0];

	// operand select for the shared 32x32 multiplier
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		unique case (cmd.op)
			jrst_pkg::OP_RAMP_MUL: begin
				mul_a   = {16'b0, diff_mag[15:0]};
				mul_b   = {15'b0, weight_q};
				mul_neg = diff_neg;
			end
			jrst_pkg::OP_X2_MUL: begin
				mul_a = {1'b0, x_q};
				mul_b = {1'b0, x_q};
			end
			jrst_pkg::OP_T_MUL: begin
				mul_a = t_q;
				mul_b = {1'b0, x2_q};
			end
			jrst_pkg::OP_R_MUL: begin
				mul_a = {1'b0, x_q};
				mul_b = t_q;
			end
			jrst_pkg::OP_AV_MUL: begin
				mul_a = {17'b0, swing_amp_q};
				mul_b = {16'b0, vel_scale_q};
			end
			jrst_pkg::OP_POS_MUL: begin
				mul_a   = {17'b0, swing_amp_q};
				mul_b   = {17'b0, sin_mag};
				mul_neg = sin_q[15];
			end
			jrst_pkg::OP_VEL_MUL: begin
				mul_a   = {1'b0, av_q};
				mul_b   = {17'b0, cos_mag};
				mul_neg = cos_q[15];
			end
			default: ;
		endcase
	end

	// angle folding into the first quadrant
	assign idx   = phase_q[31 -: TB] + (cmd.cos_sel ? QUARTER : '0);
	assign q     = {idx, {(32 - TB){1'b0}}};
	assign x_raw = {1'b0, q[29:0]};

	// polynomial result to Q1.15, round half up, clamp, apply sign
	assign r_full   = prod_q[62:30];
	assign r_sum    = {1'b0, r_full} + 34'd16384;
	assign r_q15    = r_sum[33:15];
	assign r_mag    = (r_q15 > 19'd32767) ? 15'h7fff : r_q15[14:0];
	assign r_signed = quad_q[1] ? 16'(-{1'b0, r_mag}) : {1'b0, r_mag};

	// floor shifts of a signed product
	assign sprod = neg_q ? -$signed(prod_q) : $signed(prod_q);
	assign sh15  = sprod >>> 15;
	assign sh16  = sprod >>> 16;
	assign sh27  = sprod >>> 27;

	assign step_eff  = (ramp_step_q == '0) ? 16'd1 : ramp_step_q;
	assign weight_nx = {1'b0, weight_q} + {2'b0, step_eff};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_pos_q <= '0;
			swing_amp_q   <= '0;
			phase_step_q  <= '0;
			vel_scale_q   <= '0;
			ramp_step_q   <= jrst_pkg::RAMP_STEP_RST;
			gain_p_q      <= '0;
			gain_d_q      <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				jrst_pkg::REG_DEFAULT_POS: default_pos_q <= cfg_data[15:0];
				jrst_pkg::REG_SWING_AMP:   swing_amp_q   <= cfg_data[14:0];
				jrst_pkg::REG_PHASE_STEP:  phase_step_q  <= cfg_data;
				jrst_pkg::REG_VEL_SCALE:   vel_scale_q   <= cfg_data[15:0];
				jrst_pkg::REG_RAMP_STEP:   ramp_step_q   <= cfg_data[15:0];
				jrst_pkg::REG_GAIN_P:      gain_p_q      <= cfg_data[15:0];
				jrst_pkg::REG_GAIN_D:      gain_d_q      <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q    <= '0;
			weight_q   <= '0;
			phase_q    <= '0;
			swinging_q <= 1'b0;
		end else begin
			unique case (cmd.op)
				jrst_pkg::OP_ENTER: begin
					start_q    <= measured_pos;
					weight_q   <= '0;
					phase_q    <= '0;
					swinging_q <= 1'b0;
				end
				jrst_pkg::OP_RAMP_FIN: begin
					if (weight_nx >= {1'b0, jrst_pkg::WEIGHT_ONE}) begin
						weight_q   <= jrst_pkg::WEIGHT_ONE;
						swinging_q <= 1'b1;
					end else begin
						weight_q <= weight_nx[16:0];
					end
				end
				jrst_pkg::OP_SWING_FIN: phase_q <= phase_q + phase_step_q;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			jrst_pkg::OP_RAMP_MUL, jrst_pkg::OP_X2_MUL, jrst_pkg::OP_T_MUL,
			jrst_pkg::OP_R_MUL, jrst_pkg::OP_AV_MUL, jrst_pkg::OP_POS_MUL,
			jrst_pkg::OP_VEL_MUL: begin
				prod_q <= mul_a * mul_b;
				neg_q  <= mul_neg;
			end
			jrst_pkg::OP_SIN_SETUP: begin
				quad_q <= q[31:30];
				x_q    <= q[30] ? (jrst_pkg::Q30_ONE - x_raw) : x_raw;
			end
			jrst_pkg::OP_X2_FIN: begin
				x2_q <= prod_q[60:30];
				t_q  <= jrst_pkg::SIN_C9;
			end
			jrst_pkg::OP_T_FIN: t_q <= jrst_pkg::sin_coef(cmd.coef) - prod_q[61:30];
			jrst_pkg::OP_R_FIN: begin
				if (cmd.cos_sel)
					cos_q <= r_signed;
				else
					sin_q <= r_signed;
			end
			jrst_pkg::OP_AV_FIN: av_q <= prod_q[30:0];
			jrst_pkg::OP_POS_FIN:
				pos_q <= jrst_pkg::sat16({{8{default_pos_q[15]}}, default_pos_q} + sh15[23:0]);
			jrst_pkg::OP_RAMP_FIN: begin
				target_pos <= jrst_pkg::sat16({{8{start_q[15]}}, start_q} + sh16[23:0]);
				ref_vel    <= '0;
				gain_p     <= gain_p_q;
				gain_d     <= gain_d_q;
				in_swing   <= 1'b0;
			end
			jrst_pkg::OP_SWING_FIN: begin
				target_pos <= pos_q;
				ref_vel    <= jrst_pkg::sat16(sh27[23:0]);
				gain_p     <= gain_p_q;
				gain_d     <= gain_d_q;
				in_swing   <= 1'b1;
			end
			default: ;
		endcase
	end

	`JRST_ASSERT_IMP(a_swing_weight_full, clk, arst_n, swinging_q,
		weight_q == jrst_pkg::WEIGHT_ONE)
	`JRST_ASSERT_IMP(a_ramp_weight_below, clk, arst_n, !swinging_q,
		weight_q < jrst_pkg::WEIGHT_ONE)
	`JRST_ASSERT_NXT(a_phase_advance, clk, arst_n, cmd.op == jrst_pkg::OP_SWING_FIN,
		phase_q == $past(phase_q) + $past(phase_step_q))

endmodule

@@ design/jrst_ctrl.sv @@
// Controller: sequences the datapath through ramp and swing ticks.
`include "joint_ramp_then_sine_trajectory_macros.svh"

module jrst_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	output logic               out_valid,
	input  logic               out_ready,
	input  jrst_pkg::dp_stat_t stat,
	output jrst_pkg::dp_cmd_t  cmd
);

	typedef enum logic [14:0] {
		S_IDLE     = 15'h0001,
		S_RAMP_MUL = 15'h0002,
		S_SETUP    = 15'h0004,
		S_X2_MUL   = 15'h0008,
		S_X2_FIN   = 15'h0010,
		S_T_MUL    = 15'h0020,
		S_T_FIN    = 15'h0040,
		S_R_MUL    = 15'h0080,
		S_R_FIN    = 15'h0100,
		S_AV_MUL   = 15'h0200,
		S_AV_FIN   = 15'h0400,
		S_POS_MUL  = 15'h0800,
		S_POS_FIN  = 15'h1000,
		S_VEL_MUL  = 15'h2000,
		S_FIN      = 15'h4000
	} ctrl_state_t;

	ctrl_state_t        state_q;
	ctrl_state_t        state_nx;
	jrst_pkg::dp_op_t   op_nx;
	logic               out_valid_q;
	logic               swing_item_q;
	logic               cos_sel_q;
	logic [1:0]         k_q;
	logic               accept;
	logic               slot_free;
	logic               fin_fire;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign fin_fire  = (state_q == S_FIN) && slot_free;
	assign out_valid = out_valid_q;

	assign cmd.op      = op_nx;
	assign cmd.cos_sel = cos_sel_q;
	assign cmd.coef    = k_q;

	always_comb begin
		state_nx = state_q;
		op_nx    = jrst_pkg::OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!mode)
						op_nx = jrst_pkg::OP_ENTER;
					else if (stat.swinging)
						state_nx = S_SETUP;
					else
						state_nx = S_RAMP_MUL;
				end
			end
			S_RAMP_MUL: begin
				op_nx    = jrst_pkg::OP_RAMP_MUL;
				state_nx = S_FIN;
			end
			S_SETUP: begin
				op_nx    = jrst_pkg::OP_SIN_SETUP;
				state_nx = S_X2_MUL;
			end
			S_X2_MUL: begin
				op_nx    = jrst_pkg::OP_X2_MUL;
				state_nx = S_X2_FIN;
			end
			S_X2_FIN: begin
				op_nx    = jrst_pkg::OP_X2_FIN;
				state_nx = S_T_MUL;
			end
			S_T_MUL: begin
				op_nx    = jrst_pkg::OP_T_MUL;
				state_nx = S_T_FIN;
			end
			S_T_FIN: begin
				op_nx    = jrst_pkg::OP_T_FIN;
				state_nx = (k_q == 2'd3) ? S_R_MUL : S_T_MUL;
			end
			S_R_MUL: begin
				op_nx    = jrst_pkg::OP_R_MUL;
				state_nx = S_R_FIN;
			end
			S_R_FIN: begin
				op_nx    = jrst_pkg::OP_R_FIN;
				state_nx = cos_sel_q ? S_AV_MUL : S_SETUP;
			end
			S_AV_MUL: begin
				op_nx    = jrst_pkg::OP_AV_MUL;
				state_nx = S_AV_FIN;
			end
			S_AV_FIN: begin
				op_nx    = jrst_pkg::OP_AV_FIN;
				state_nx = S_POS_MUL;
			end
			S_POS_MUL: begin
				op_nx    = jrst_pkg::OP_POS_MUL;
				state_nx = S_POS_FIN;
			end
			S_POS_FIN: begin
				op_nx    = jrst_pkg::OP_POS_FIN;
				state_nx = S_VEL_MUL;
			end
			S_VEL_MUL: begin
				op_nx    = jrst_pkg::OP_VEL_MUL;
				state_nx = S_FIN;
			end
			S_FIN: begin
				// hold here while the previous result is still unclaimed
				if (slot_free) begin
					op_nx    = swing_item_q ? jrst_pkg::OP_SWING_FIN : jrst_pkg::OP_RAMP_FIN;
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			swing_item_q <= 1'b0;
			cos_sel_q    <= 1'b0;
			k_q          <= '0;
		end else begin
			state_q <= state_nx;
			if (fin_fire)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				swing_item_q <= stat.swinging;
				cos_sel_q    <= 1'b0;
			end
			if (state_q == S_R_FIN)
				cos_sel_q <= 1'b1;
			if (state_q == S_X2_FIN)
				k_q <= '0;
			else if (state_q == S_T_FIN && k_q != 2'd3)
				k_q <= k_q + 2'd1;
		end
	end

	`JRST_ASSERT_NXT(a_tick_busy, clk, arst_n, accept && mode, !in_ready)
	`JRST_ASSERT_IMP(a_coef_done, clk, arst_n, state_q == S_R_MUL, k_q == 2'd3)
	`JRST_ASSERT_IMP(a_sine_swing_only, clk, arst_n, state_q == S_X2_MUL, swing_item_q)

endmodule

@@ design/joint_ramp_then_sine_trajectory.sv @@
// Top level of the single-joint ramp-then-sine reference generator.
//
// Input channel (in_valid/in_ready) takes one request per item: mode 0 captures
// measured_pos as the ramp start and restarts the sequence (no result), mode 1
// is a control tick that yields one result on the output channel
// (out_valid/out_ready): target_pos, ref_vel, gain_p, gain_d, in_swing.
// Configuration writes use cfg_valid/cfg_ready with cfg_index and cfg_data;
// cfg_ready is always high and indexes above six are dropped. Write only
// while the block is idle.
// An enter request is executed on acceptance and the block stays idle. A ramp
// tick passes through a multiply step and the final step before its result is
// loaded; a swing tick evaluates sine, cosine, position and velocity, all through
// one shared 32x32 multiplier with a multiply step and a finish step per product
// (32 sequencer steps). The next request is taken in the cycle after the result
// is loaded, so a new tick is not accepted until the previous one is through.
// The result sits in an output register; while out_ready is low it holds, and
// a finished follow-on tick waits in its last step until the register frees.
// Reset clears the joint state and loads the register defaults (ramp step 22).
module joint_ramp_then_sine_trajectory (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           mode,
	input  logic signed [15:0]             measured_pos,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [15:0]             target_pos,
	output logic signed [15:0]             ref_vel,
	output logic [15:0]                    gain_p,
	output logic [15:0]                    gain_d,
	output logic                           in_swing,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [jrst_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);

	jrst_pkg::dp_cmd_t  cmd;
	jrst_pkg::dp_stat_t stat;

	assign cfg_ready = 1'b1;

	jrst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	jrst_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.measured_pos (measured_pos),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.target_pos   (target_pos),
		.ref_vel      (ref_vel),
		.gain_p       (gain_p),
		.gain_d       (gain_d),
		.in_swing     (in_swing)
	);

endmodule
